// ===== rtl/core/pol_pkg.sv =====
//------------------------------------------------------------------------------
// pol_pkg
// Shared widths, operation codes and types of the positional ordered list.
//------------------------------------------------------------------------------
`default_nettype none

package pol_pkg;

	// Storage geometry
	localparam int CAPACITY   = 16;
	localparam int VALUE_BITS = 32;

	// Fixed item field widths
	localparam int OP_W   = 3;
	localparam int POS_W  = 5;
	localparam int DATA_W = 32;
	localparam int CNTO_W = 5;

	// Derived widths
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	// Operation codes
	localparam logic [OP_W-1:0] OP_ADD_FRONT = 3'd0;
	localparam logic [OP_W-1:0] OP_ADD_REAR  = 3'd1;
	localparam logic [OP_W-1:0] OP_RMV_FRONT = 3'd2;
	localparam logic [OP_W-1:0] OP_RMV_REAR  = 3'd3;
	localparam logic [OP_W-1:0] OP_INS_AT    = 3'd4;
	localparam logic [OP_W-1:0] OP_RMV_AT    = 3'd5;

	// Shift command broadcast to every cell
	typedef struct packed {
		logic                  ins;
		logic                  del;
		logic [IDX_W-1:0]      pos;
		logic [VALUE_BITS-1:0] value;
	} pol_shift_t;

	// Request outcome from the controller
	typedef struct packed {
		logic             ok;
		logic [CNT_W-1:0] count;
	} pol_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/pol_if.sv =====
//------------------------------------------------------------------------------
// pol_if
// Valid/ready channels for list requests and list responses.
//------------------------------------------------------------------------------
`default_nettype none

interface pol_req_if;
	logic                          valid;
	logic                          ready;
	logic [pol_pkg::OP_W-1:0]      operation;
	logic [pol_pkg::POS_W-1:0]     position;
	logic [pol_pkg::DATA_W-1:0]    value;

	modport source (output valid, output operation, output position, output value,
		input ready);
	modport sink (input valid, input operation, input position, input value,
		output ready);
endinterface

interface pol_rsp_if;
	logic                          valid;
	logic                          ready;
	logic                          ok;
	logic [pol_pkg::DATA_W-1:0]    removed_value;
	logic [pol_pkg::CNTO_W-1:0]    entry_count;
	logic                          is_empty;

	modport source (output valid, output ok, output removed_value, output entry_count,
		output is_empty, input ready);
	modport sink (input valid, input ok, input removed_value, input entry_count,
		input is_empty, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/pol_cell.sv =====
//------------------------------------------------------------------------------
// pol_cell
// One slot of the list: holds a value, takes from a neighbor on a shift.
//------------------------------------------------------------------------------
`default_nettype none

module pol_cell (
	input  wire                            clk,
	input  wire  [pol_pkg::IDX_W-1:0]      idx,
	input  wire  pol_pkg::pol_shift_t      cmd,
	input  wire  [pol_pkg::VALUE_BITS-1:0] left_val,
	input  wire  [pol_pkg::VALUE_BITS-1:0] right_val,
	output logic [pol_pkg::VALUE_BITS-1:0] val
);
	import pol_pkg::*;

	logic [VALUE_BITS-1:0] val_q;

	// Insert: slots behind the gap take the front neighbor, the gap takes the new value.
	// Delete: the slot removed and all behind it take the rear neighbor.
	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (idx > cmd.pos) begin
				val_q <= left_val;
			end else if (idx == cmd.pos) begin
				val_q <= cmd.value;
			end
		end else if (cmd.del) begin
			if (idx >= cmd.pos) begin
				val_q <= right_val;
			end
		end
	end

	assign val = val_q;

endmodule

`default_nettype wire

// ===== rtl/core/pol_ctrl.sv =====
//------------------------------------------------------------------------------
// pol_ctrl
// Request decode, range checks and entry count of the list.
//------------------------------------------------------------------------------
`default_nettype none

module pol_ctrl (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          accept,
	input  wire  [pol_pkg::OP_W-1:0]     operation,
	input  wire  [pol_pkg::POS_W-1:0]    position,
	input  wire  [pol_pkg::DATA_W-1:0]   value,
	output pol_pkg::pol_shift_t          cmd,
	output pol_pkg::pol_status_t         status
);
	import pol_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic [CMP_W-1:0] cnt_ext;
	logic [CMP_W-1:0] pos_ext;
	logic [CMP_W-1:0] eff_pos;
	logic             not_full;
	logic             not_empty;
	logic             is_ins;
	logic             is_del;
	logic             ok;
	logic [CNT_W-1:0] next_count;

	assign cnt_ext   = CMP_W'(count_q);
	assign pos_ext   = CMP_W'(position);
	assign not_full  = (cnt_ext < CMP_W'(CAPACITY));
	assign not_empty = (count_q != '0);

	// Decode operation into slot, direction and legality
	always_comb begin
		eff_pos = '0;
		is_ins  = 1'b0;
		is_del  = 1'b0;
		ok      = 1'b0;
		unique case (operation)
			OP_ADD_FRONT: begin
				is_ins = 1'b1;
				ok     = not_full;
			end
			OP_ADD_REAR: begin
				eff_pos = cnt_ext;
				is_ins  = 1'b1;
				ok      = not_full;
			end
			OP_RMV_FRONT: begin
				is_del = 1'b1;
				ok     = not_empty;
			end
			OP_RMV_REAR: begin
				eff_pos = cnt_ext - CMP_W'(1);
				is_del  = 1'b1;
				ok      = not_empty;
			end
			OP_INS_AT: begin
				eff_pos = pos_ext;
				is_ins  = 1'b1;
				ok      = not_full && (pos_ext <= cnt_ext);
			end
			OP_RMV_AT: begin
				eff_pos = pos_ext;
				is_del  = 1'b1;
				ok      = (pos_ext < cnt_ext);
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

	// Shift command only fires on an accepted, legal item
	assign cmd.ins   = accept && ok && is_ins;
	assign cmd.del   = accept && ok && is_del;
	assign cmd.pos   = eff_pos[IDX_W-1:0];
	assign cmd.value = VALUE_BITS'(value);

	always_comb begin
		next_count = count_q;
		if (ok && is_ins) begin
			next_count = count_q + CNT_W'(1);
		end else if (ok && is_del) begin
			next_count = count_q - CNT_W'(1);
		end
	end

	assign status.ok    = ok;
	assign status.count = next_count;

	// Entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= next_count;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/positional_ordered_list.sv =====
//------------------------------------------------------------------------------
// positional_ordered_list
// Bounded ordered list with insert and remove at front, rear or any position.
//------------------------------------------------------------------------------
// The list accepts one request item per clock and returns its response item on
// the following cycle through an output register; a new request is taken while
// a response waits, as long as the response side is not stalled. All slots sit
// in a row of cells that shift toward or away from their neighbors in the same
// cycle, regardless of position or count. Slot 0 is the front. Failed requests
// change nothing and report ok low and a removed value of zero. No clearing is
// needed after reset.
`default_nettype none

module positional_ordered_list (
	input  wire        clk,
	input  wire        arst_n,
	pol_req_if.sink    req,
	pol_rsp_if.source  rsp
);
	import pol_pkg::*;

	pol_shift_t            cmd;
	pol_status_t           status;
	logic                  accept;
	logic [VALUE_BITS-1:0] cell_val [CAPACITY];
	logic [VALUE_BITS-1:0] rmv_val;

	logic                  rsp_valid_q;
	logic                  ok_q;
	logic [DATA_W-1:0]     rmv_q;
	logic [CNTO_W-1:0]     cnt_q;
	logic                  empty_q;

	// Take a request when the response slot is free or being drained
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	pol_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.operation (req.operation),
		.position  (req.position),
		.value     (req.value),
		.cmd       (cmd),
		.status    (status)
	);

	// Row of cells, each linked to its front and rear neighbors
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [VALUE_BITS-1:0] left_v;
		logic [VALUE_BITS-1:0] right_v;

		if (i == 0) begin : g_first
			assign left_v = cell_val[i];
		end else begin : g_mid_l
			assign left_v = cell_val[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_v = cell_val[i];
		end else begin : g_mid_r
			assign right_v = cell_val[i+1];
		end

		pol_cell u_cell (
			.clk       (clk),
			.idx       (IDX_W'(i)),
			.cmd       (cmd),
			.left_val  (left_v),
			.right_val (right_v),
			.val       (cell_val[i])
		);
	end

	// Pick the value leaving the list
	always_comb begin
		rmv_val = '0;
		for (int k = 0; k < CAPACITY; k++) begin
			if (cmd.del && (IDX_W'(k) == cmd.pos)) begin
				rmv_val = rmv_val | cell_val[k];
			end
		end
	end

	// Response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ok_q    <= status.ok;
			rmv_q   <= DATA_W'(rmv_val);
			cnt_q   <= CNTO_W'(status.count);
			empty_q <= (status.count == '0);
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.ok            = ok_q;
	assign rsp.removed_value = rmv_q;
	assign rsp.entry_count   = cnt_q;
	assign rsp.is_empty      = empty_q;

endmodule

`default_nettype wire

// ===== rtl/core/pol_checker.sv =====
//------------------------------------------------------------------------------
// pol_checker
// Port-level checks of the positional ordered list, bound to its top level.
//------------------------------------------------------------------------------
`default_nettype none

module pol_checker (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          req_valid,
	input wire                          req_ready,
	input wire                          rsp_valid,
	input wire                          rsp_ready,
	input wire                          rsp_ok,
	input wire [pol_pkg::DATA_W-1:0]    rsp_removed_value,
	input wire [pol_pkg::CNTO_W-1:0]    rsp_entry_count,
	input wire                          rsp_is_empty
);
	import pol_pkg::*;

	// Every accepted item gives a response on the next cycle
	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> rsp_valid)
		else $error("accepted item produced no response");

	// Requests flow while no response is pending
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("request stalled with empty response slot");

	// Empty flag agrees with the count
	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_is_empty == (rsp_entry_count == '0)))
		else $error("empty flag disagrees with count");

	// A failed request removes nothing
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ok |-> (rsp_removed_value == '0))
		else $error("failed request reported a removed value");

	// A stalled response stays offered
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

endmodule

bind positional_ordered_list pol_checker u_pol_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_ok            (rsp.ok),
	.rsp_removed_value (rsp.removed_value),
	.rsp_entry_count   (rsp.entry_count),
	.rsp_is_empty      (rsp.is_empty)
);

`default_nettype wire
